[design/ghh_pkg.sv]
// Shared constants, register indexes and the controller state type for the height histogram.
package ghh_pkg;

   // Field and register widths
   localparam int Z_WIDTH   = 24;
   localparam int CFG_WIDTH = 16;

   // Parameter defaults
   localparam int BIN_COUNT_DEF   = 256;
   localparam int COUNT_WIDTH_DEF = 16;

   // Register indexes on the csr port
   localparam logic CSR_BIN_SIZE  = 1'b0;
   localparam logic CSR_MIN_COUNT = 1'b1;

   // Register reset values
   localparam logic [CFG_WIDTH-1:0] BIN_SIZE_RST  = 16'd100;
   localparam logic [CFG_WIDTH-1:0] MIN_COUNT_RST = 16'd10;

   // Output height limits
   localparam logic signed [Z_WIDTH-1:0] Z_MAX = 24'sh7FFFFF;
   localparam logic signed [Z_WIDTH-1:0] Z_MIN = 24'sh800000;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_RD,
      ST_WR,
      ST_SCAN,
      ST_MUL,
      ST_OUT
   } state_type;

endpackage

[design/ghh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ghh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ghh_div.sv]
// Bit-serial restoring divider: unsigned height magnitude by bin size, one quotient bit a cycle.
module ghh_div
   import ghh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [Z_WIDTH-1:0]   dividend,
   input  logic [CFG_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [Z_WIDTH-1:0]   quotient
);

   localparam int CW = $clog2(Z_WIDTH);
   localparam logic [CW-1:0] LAST_STEP = CW'(Z_WIDTH - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CFG_WIDTH-1:0] rem_ff, rem_in;
   logic [Z_WIDTH-1:0]   quo_ff, quo_in;

   logic [CFG_WIDTH:0]   rem_sh;
   logic [CFG_WIDTH:0]   rem_sub;
   logic                 q_bit;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[Z_WIDTH-1]};
      rem_sub = rem_sh - {1'b0, divisor};
      q_bit   = (rem_sh >= {1'b0, divisor});
   end

   // Step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = q_bit ? rem_sub[CFG_WIDTH-1:0] : rem_sh[CFG_WIDTH-1:0];
         quo_in = {quo_ff[Z_WIDTH-2:0], q_bit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath shift registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[design/ground_height_histogram.sv]
// Each point's height is divided serially by the bin size and its bin read and written before the next is accepted.
// The last point of a cloud adds a scan-and-clear sweep of the bins, a multiply step and an output step.
// The one-bit-per-cycle divider and the single RAM port pair set the pace at which points are taken.
// Reset: synchronous, active high; control and configuration registers reset, then a pass zeroes the histogram RAM.
// req_stall stays high during that pass; csr writes are taken at any time.
module ground_height_histogram
   import ghh_pkg::*;
#(
   parameter int BIN_COUNT   = BIN_COUNT_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Point input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [Z_WIDTH-1:0] req_z_value,
   input  logic                      req_is_last,
   // Result output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic signed [Z_WIDTH-1:0] rsp_ground_height,
   // Configuration
   input  logic                      csr_write,
   input  logic [0:0]                csr_index,
   input  logic [CFG_WIDTH-1:0]      csr_data
);

   localparam int IW    = $clog2(BIN_COUNT);
   localparam int HALF  = BIN_COUNT / 2;
   localparam int HI    = BIN_COUNT - HALF - 1;
   localparam int CMP_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int PW    = IW + 1 + CFG_WIDTH + 1;
   localparam int EW    = (PW > Z_WIDTH) ? PW : Z_WIDTH;

   localparam logic [Z_WIDTH-1:0] HALF_Z  = Z_WIDTH'(HALF);
   localparam logic [Z_WIDTH-1:0] HI_Z    = Z_WIDTH'(HI);
   localparam logic [IW:0]        HALF_S  = (IW + 1)'(HALF);
   localparam logic [IW:0]        SCAN_END = (IW + 1)'(BIN_COUNT);
   localparam logic [IW:0]        CLR_LAST = (IW + 1)'(BIN_COUNT - 1);
   localparam logic signed [EW-1:0] HMAX_E = EW'(Z_MAX);
   localparam logic signed [EW-1:0] HMIN_E = EW'(Z_MIN);

   // Configuration registers
   logic [CFG_WIDTH-1:0] bin_size_ff, bin_size_in;
   logic [CFG_WIDTH-1:0] min_count_ff, min_count_in;
   logic [CFG_WIDTH-1:0] bs_eff;

   // Control state
   state_type            state_ff, state_in;
   logic [IW:0]          scan_cnt_ff, scan_cnt_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IW-1:0]        chk_addr_ff, chk_addr_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        found_bin_ff, found_bin_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Point datapath
   logic                 neg_ff, neg_in;
   logic                 last_ff, last_in;
   logic [IW-1:0]        slot_ff, slot_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic signed [Z_WIDTH-1:0] rsp_height_ff, rsp_height_in;

   // Decoded controls
   logic                 accept;
   logic                 rsp_free;
   logic                 div_start;
   logic                 div_done;
   logic [Z_WIDTH-1:0]   div_quo;
   logic [Z_WIDTH-1:0]   mag;
   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [COUNT_WIDTH-1:0] ram_wr_data;
   logic                 ram_rd_en;
   logic [IW-1:0]        ram_rd_addr;
   logic [COUNT_WIDTH-1:0] ram_rd_data;
   logic                 bin_hit;
   logic [IW-1:0]        qc;
   logic [IW:0]          slot_sum;
   logic signed [IW+1:0] bin_off;
   logic signed [EW-1:0] prod_ext;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign bs_eff   = (bin_size_ff == '0) ? CFG_WIDTH'(1) : bin_size_ff;
   assign mag      = req_z_value[Z_WIDTH-1] ? Z_WIDTH'(-req_z_value) : req_z_value;

   // Configuration writes
   always_comb begin
      bin_size_in  = bin_size_ff;
      min_count_in = min_count_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BIN_SIZE:  bin_size_in  = csr_data;
            CSR_MIN_COUNT: min_count_in = csr_data;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_size_ff  <= BIN_SIZE_RST;
         min_count_ff <= MIN_COUNT_RST;
      end else begin
         bin_size_ff  <= bin_size_in;
         min_count_ff <= min_count_in;
      end
   end

   // Serial divider
   ghh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .divisor  (bs_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Histogram store
   ghh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (BIN_COUNT)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (scan_cnt_ff == CLR_LAST) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_RD;
         ST_RD:    state_in = ST_WR;
         ST_WR:    state_in = last_ff ? ST_SCAN : ST_IDLE;
         ST_SCAN:  if (scan_cnt_ff == SCAN_END) state_in = ST_MUL;
         ST_MUL:   state_in = ST_OUT;
         ST_OUT:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall   = 1'b1;
      div_start   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = slot_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_ff;
      ram_wr_data = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = scan_cnt_ff[IW-1:0];
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            div_start = req_valid;
         end
         ST_RD: begin
            ram_rd_en = 1'b1;
         end
         ST_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + 1'b1;
         end
         ST_SCAN: begin
            ram_rd_en   = (scan_cnt_ff != SCAN_END);
            ram_rd_addr = scan_cnt_ff[IW-1:0];
            ram_wr_en   = chk_vld_ff;
            ram_wr_addr = chk_addr_ff;
         end
         default: ;
      endcase
   end

   // Bin index clamp from the quotient
   always_comb begin
      if (neg_ff) begin
         qc       = (div_quo > HALF_Z) ? HALF_Z[IW-1:0] : div_quo[IW-1:0];
         slot_sum = HALF_S - {1'b0, qc};
      end else begin
         qc       = (div_quo > HI_Z) ? HI_Z[IW-1:0] : div_quo[IW-1:0];
         slot_sum = HALF_S + {1'b0, qc};
      end
   end

   // Scan compare: non-empty and at or above the threshold
   assign bin_hit = (ram_rd_data != '0) &&
                    (CMP_W'(ram_rd_data) >= CMP_W'(min_count_ff));

   // Height product and saturation
   assign bin_off  = signed'({2'b00, found_bin_ff}) - signed'({1'b0, HALF_S});
   assign prod_ext = EW'(prod_ff);

   // Datapath next values
   always_comb begin
      neg_in        = neg_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      scan_cnt_in   = '0;
      chk_vld_in    = 1'b0;
      chk_addr_in   = scan_cnt_ff[IW-1:0];
      found_in      = found_ff;
      found_bin_in  = found_bin_ff;
      prod_in       = prod_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_height_in = rsp_height_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (accept) begin
         neg_in  = req_z_value[Z_WIDTH-1];
         last_in = req_is_last;
      end
      if (state_ff == ST_DIV && div_done) begin
         slot_in = slot_sum[IW-1:0];
      end
      if (state_ff == ST_CLEAR) begin
         scan_cnt_in = scan_cnt_ff + 1'b1;
      end
      if (state_ff == ST_WR) begin
         found_in = 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         if (scan_cnt_ff != SCAN_END) begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            chk_vld_in  = 1'b1;
         end
         // First qualifying bin from the bottom wins
         if (chk_vld_ff && bin_hit && !found_ff) begin
            found_in     = 1'b1;
            found_bin_in = chk_addr_ff;
         end
      end
      if (state_ff == ST_MUL) begin
         prod_in = PW'(bin_off * signed'({1'b0, bs_eff}));
      end
      if (state_ff == ST_OUT && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         if (!found_ff) begin
            rsp_height_in = '0;
         end else if (prod_ext > HMAX_E) begin
            rsp_height_in = Z_MAX;
         end else if (prod_ext < HMIN_E) begin
            rsp_height_in = Z_MIN;
         end else begin
            rsp_height_in = prod_ext[Z_WIDTH-1:0];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_cnt_ff  <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      last_ff       <= last_in;
      slot_ff       <= slot_in;
      chk_addr_ff   <= chk_addr_in;
      found_bin_ff  <= found_bin_in;
      prod_ff       <= prod_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_height_ff <= rsp_height_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_ground_height = rsp_height_ff;

`ifndef SYNTHESIS
   // Scan clear never writes the bin being read
   assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("histogram read and write collide");

   // Divider completes only while the controller waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide state");

   // A not-found result carries zero height
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_ground_height == '0))
      else $error("nonzero height without a found bin");

   // The last point of a cloud always starts a scan
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR && last_ff) |=> (state_ff == ST_SCAN))
      else $error("last point did not start the scan");

   // A finished result is never overwritten while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_ground_height)))
      else $error("stalled result lost");
`endif

endmodule
